>>> rtl/sp2c_pkg.sv
package sp2c_pkg;

  // CORDIC iterations and fraction bits of the rotation datapath
  localparam int TRIG_BITS = 16;
  localparam int GUARD     = TRIG_BITS + 2;
  localparam int CW        = GUARD + 3;
  localparam int ZW        = 33;
  localparam int NST       = (TRIG_BITS + 1) / 2;
  localparam int PW        = CW + 17;

  localparam longint GAIN_Q30 = 64'sd652032874;
  localparam longint X_INIT   = (GAIN_Q30 + (64'sd1 <<< (29 - GUARD))) >>> (30 - GUARD);

  localparam int COORD_MAX = 65535;

  localparam logic [31:0] QUARTER_TURN      = 32'h4000_0000;
  localparam logic [31:0] START_ANGLE_RESET = 32'hA000_0000;
  localparam logic [24:0] ANGLE_STEP_RESET  = 25'd9544372;
  localparam logic [7:0]  DECIMATION_RESET  = 8'd1;
  localparam logic [31:0] BAND_LOW_RESET    = 32'd201326592;
  localparam logic [31:0] BAND_HIGH_RESET   = 32'd671088640;
  localparam logic [31:0] REAR_LIMIT_RESET  = 32'd1342177280;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ANGLE,
    REG_ANGLE_STEP,
    REG_DECIMATION,
    REG_BAND_LOW,
    REG_BAND_HIGH,
    REG_REAR_LIMIT
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cord_t;

  typedef struct packed {
    logic        point;
    logic        last;
    logic        flip;
    logic [15:0] range;
  } meta_t;

  function automatic logic signed [ZW-1:0] atan_val(input int i);
    case (i)
      0:       atan_val = 33'sd536870912;
      1:       atan_val = 33'sd316933406;
      2:       atan_val = 33'sd167458907;
      3:       atan_val = 33'sd85004756;
      4:       atan_val = 33'sd42667331;
      5:       atan_val = 33'sd21354465;
      6:       atan_val = 33'sd10679838;
      7:       atan_val = 33'sd5340245;
      8:       atan_val = 33'sd2670163;
      9:       atan_val = 33'sd1335087;
      10:      atan_val = 33'sd667544;
      11:      atan_val = 33'sd333772;
      12:      atan_val = 33'sd166886;
      13:      atan_val = 33'sd83443;
      14:      atan_val = 33'sd41722;
      15:      atan_val = 33'sd20861;
      16:      atan_val = 33'sd10430;
      17:      atan_val = 33'sd5215;
      18:      atan_val = 33'sd2608;
      19:      atan_val = 33'sd1304;
      20:      atan_val = 33'sd652;
      21:      atan_val = 33'sd326;
      22:      atan_val = 33'sd163;
      23:      atan_val = 33'sd81;
      default: atan_val = '0;
    endcase
  endfunction

  // one rotation step toward z = 0
  function automatic cord_t cordic_iter(input cord_t c, input int i);
    cord_t                r;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.z[ZW-1]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - atan_val(i);
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + atan_val(i);
    end
    return r;
  endfunction

endpackage

>>> rtl/scan_polar_to_cartesian_masked.sv
// Laser scan polar-to-cartesian converter with angle masking.
// Sample channel (sample_valid/sample_ready): one range sample per beat, with
// scan_last on the final sample of a scan. Result channel (result_valid/
// result_ready): pos_x/pos_y in mm, point_valid and scan_end. A sample yields
// at most one result; skipped or masked samples yield none, except that the
// last sample of a scan always yields a beat with scan_end set.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
// six setup registers; cfg_ready is always high. Write only while idle.
// Throughput: one sample per cycle while the receiver does not stall. A sample
// passes through the sample register, the mask stage, the CORDIC pipeline of
// two rotation steps per stage and the multiply and rounding stages.
// When the receiver stalls, the whole pipeline holds and sample_ready drops in
// the same cycle; nothing is lost.
// Reset clears all pipeline valid bits, loads the default setup registers and
// restarts the scan angle at the start angle with no samples to skip.
module scan_polar_to_cartesian_masked import sp2c_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic [15:0]          range_mm,
  input  logic                 scan_last,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic signed [16:0]   pos_x,
  output logic signed [16:0]   pos_y,
  output logic                 point_valid,
  output logic                 scan_end
);

  logic  adv;
  logic  f_vld;
  cord_t f_cord;
  meta_t f_meta;
  logic  c_vld;
  cord_t c_cord;
  meta_t c_meta;
  logic [16:0] px;
  logic [16:0] py;

  sp2c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .range_mm     (range_mm),
    .scan_last    (scan_last),
    .adv          (adv),
    .stg_vld      (f_vld),
    .stg_cord     (f_cord),
    .stg_meta     (f_meta)
  );

  sp2c_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_vld   (f_vld),
    .in_cord  (f_cord),
    .in_meta  (f_meta),
    .out_vld  (c_vld),
    .out_cord (c_cord),
    .out_meta (c_meta)
  );

  sp2c_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .in_vld       (c_vld),
    .in_cord      (c_cord),
    .in_meta      (c_meta),
    .adv          (adv),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pos_x        (px),
    .pos_y        (py),
    .point_valid  (point_valid),
    .scan_end     (scan_end)
  );

  assign pos_x = $signed(px);
  assign pos_y = $signed(py);

  a_no_empty_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (point_valid || scan_end))
    else $error("result beat with neither point nor end mark");

  a_end_only_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !point_valid) |-> (pos_x == 17'sd0 && pos_y == 17'sd0))
    else $error("end-only beat carries nonzero coordinates");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    (result_valid && point_valid) |-> (px != 17'h10000 && py != 17'h10000))
    else $error("coordinate outside saturation range");

  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    sample_ready == (!result_valid || result_ready))
    else $error("sample intake not tied to result stall");

endmodule

>>> rtl/sp2c_front.sv
module sp2c_front import sp2c_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  logic [15:0]          range_mm,
  input  logic                 scan_last,
  input  logic                 adv,
  output logic                 stg_vld,
  output cord_t                stg_cord,
  output meta_t                stg_meta
);

  logic [31:0] start_angle;
  logic [24:0] angle_step;
  logic [7:0]  decimation;
  logic [31:0] band_low;
  logic [31:0] band_high;
  logic [31:0] rear_limit;

  logic [31:0] angle_acc;
  logic [7:0]  skip_count;
  logic [31:0] angle_acc_next;
  logic [7:0]  skip_count_next;

  logic        s0_vld;
  logic [31:0] s0_angle;
  logic        s0_used;
  logic        s0_last;
  logic [15:0] s0_range;

  logic        accept;
  logic        used;
  logic [31:0] mag;
  logic        dropped;
  logic        point;
  logic [31:0] quarter;
  logic        flip;
  logic [31:0] rot;

  assign cfg_ready    = 1'b1;
  assign sample_ready = adv;
  assign accept       = sample_valid && adv;
  assign used         = (skip_count == 8'd0);

  always_comb begin
    if (scan_last) begin
      angle_acc_next  = start_angle;
      skip_count_next = 8'd0;
    end else begin
      angle_acc_next = angle_acc + {7'd0, angle_step};
      if (!used) begin
        skip_count_next = skip_count - 8'd1;
      end else if (decimation == 8'd0) begin
        skip_count_next = 8'd0;
      end else begin
        skip_count_next = decimation - 8'd1;
      end
    end
  end

  // mask test and half-turn fold on the registered sample angle
  assign mag     = s0_angle[31] ? (32'd0 - s0_angle) : s0_angle;
  assign dropped = ((mag > band_low) && (mag < band_high)) || (mag > rear_limit);
  assign point   = s0_used && !dropped;
  assign quarter = s0_angle + QUARTER_TURN;
  assign flip    = quarter[31];
  assign rot     = {s0_angle[31] ^ flip, s0_angle[30:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      start_angle <= START_ANGLE_RESET;
      angle_step  <= ANGLE_STEP_RESET;
      decimation  <= DECIMATION_RESET;
      band_low    <= BAND_LOW_RESET;
      band_high   <= BAND_HIGH_RESET;
      rear_limit  <= REAR_LIMIT_RESET;
      angle_acc   <= START_ANGLE_RESET;
      skip_count  <= 8'd0;
      s0_vld      <= 1'b0;
      stg_vld     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_START_ANGLE: start_angle <= cfg_data;
          REG_ANGLE_STEP:  angle_step  <= cfg_data[24:0];
          REG_DECIMATION:  decimation  <= cfg_data[7:0];
          REG_BAND_LOW:    band_low    <= cfg_data;
          REG_BAND_HIGH:   band_high   <= cfg_data;
          REG_REAR_LIMIT:  rear_limit  <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        angle_acc  <= angle_acc_next;
        skip_count <= skip_count_next;
      end
      if (adv) begin
        s0_vld  <= accept;
        // drop samples that give neither a point nor an end mark
        stg_vld <= s0_vld && (point || s0_last);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_angle <= angle_acc;
      s0_used  <= used;
      s0_last  <= scan_last;
      s0_range <= range_mm;

      stg_cord.x     <= CW'(X_INIT);
      stg_cord.y     <= '0;
      stg_cord.z     <= {rot[31], rot};
      stg_meta.point <= point;
      stg_meta.last  <= s0_last;
      stg_meta.flip  <= flip;
      stg_meta.range <= s0_range;
    end
  end

endmodule

>>> rtl/sp2c_cordic.sv
module sp2c_cordic import sp2c_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_vld,
  input  cord_t in_cord,
  input  meta_t in_meta,
  output logic  out_vld,
  output cord_t out_cord,
  output meta_t out_meta
);

  cord_t          cur    [NST];
  meta_t          mcur   [NST];
  cord_t          cord_q [NST];
  meta_t          meta_q [NST];
  logic [NST-1:0] vld;

  for (genvar k = 0; k < NST; k++) begin : g_stg
    cord_t nx;

    if (k == 0) begin : g_head
      assign cur[k]  = in_cord;
      assign mcur[k] = in_meta;
    end else begin : g_body
      assign cur[k]  = cord_q[k-1];
      assign mcur[k] = meta_q[k-1];
    end

    // two rotation steps per stage
    always_comb begin
      nx = cur[k];
      for (int j = 0; j < 2; j++) begin
        if (2 * k + j < TRIG_BITS) begin
          nx = cordic_iter(nx, 2 * k + j);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cord_q[k] <= nx;
        meta_q[k] <= mcur[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_vld};
    end
  end

  assign out_vld  = vld[NST-1];
  assign out_cord = cord_q[NST-1];
  assign out_meta = meta_q[NST-1];

endmodule

>>> rtl/sp2c_scale.sv
module sp2c_scale import sp2c_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  cord_t       in_cord,
  input  meta_t       in_meta,
  output logic        adv,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [16:0] pos_x,
  output logic [16:0] pos_y,
  output logic        point_valid,
  output logic        scan_end
);

  localparam logic signed [PW:0] ROUND_HALF = (PW + 1)'(1) << (GUARD - 1);

  logic signed [16:0]   rng_s;
  logic signed [PW-1:0] mul_x;
  logic signed [PW-1:0] mul_y;

  logic                 p_vld;
  logic signed [PW-1:0] p_x;
  logic signed [PW-1:0] p_y;
  meta_t                p_meta;

  function automatic logic [16:0] round_sat(input logic signed [PW-1:0] p, input logic flip);
    logic signed [PW:0] v;
    logic signed [PW:0] q;
    v = {p[PW-1], p};
    if (flip) begin
      v = -v;
    end
    q = (v + ROUND_HALF) >>> GUARD;
    if (q > COORD_MAX) begin
      round_sat = 17'(COORD_MAX);
    end else if (q < -COORD_MAX) begin
      round_sat = 17'(-COORD_MAX);
    end else begin
      round_sat = q[16:0];
    end
  endfunction

  // the whole pipeline holds while a finished beat waits
  assign adv   = !result_valid || result_ready;
  assign rng_s = $signed({1'b0, in_meta.range});
  assign mul_x = rng_s * in_cord.x;
  assign mul_y = rng_s * in_cord.y;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld        <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      p_vld        <= in_vld;
      result_valid <= p_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x    <= mul_x;
      p_y    <= mul_y;
      p_meta <= in_meta;
      if (p_meta.point) begin
        pos_x <= round_sat(p_x, p_meta.flip);
        pos_y <= round_sat(p_y, p_meta.flip);
      end else begin
        pos_x <= '0;
        pos_y <= '0;
      end
      point_valid <= p_meta.point;
      scan_end    <= p_meta.last;
    end
  end

endmodule

>>> tb/tb_scan_polar_to_cartesian_masked.sv
module tb_scan_polar_to_cartesian_masked;
  import sp2c_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY      = TRIG_BITS / 2 + 4;
  localparam int SETTLE_BEATS = 3 * LATENCY;
  localparam int HOLD_CYCLES  = 300;
  localparam int PRESS_ITEMS  = 100;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 150;
  localparam int CYCLE_LIMIT  = 400000;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  // arctangent of 2^-i in binary angle units
  localparam longint ATAN_BAM [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [16:0] x;
    logic signed [16:0] y;
    logic               point;
    logic               last;
  } xy_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_PRED, ROW_NONE, ROW_EXP} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
    logic [15:0]          rng;
    logic                 last;
    xy_result_t           want;
  } script_row_t;

  localparam xy_result_t XY_NONE = '0;
  localparam xy_result_t XY_END  = '{17'sd0, 17'sd0, 1'b0, 1'b1};
  localparam xy_result_t XY_ZERO = '{17'sd0, 17'sd0, 1'b1, 1'b0};

  localparam int SCRIPT_LEN = 45;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // defaults after reset: first angles lie beyond the rear limit
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'd1000,  1'b0, XY_NONE},
    '{ROW_EXP,  REG_START_ANGLE, 32'h0, 16'h0000,  1'b1, XY_END},
    // fixed angle; new start only applies after the next scan end
    '{ROW_CFG,  REG_START_ANGLE, 32'h7E00_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_ANGLE_STEP,  32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_DECIMATION,  32'h0000_0001, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_BAND_LOW,    32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_BAND_HIGH,   32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_REAR_LIMIT,  32'h8000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_EXP,  REG_START_ANGLE, 32'h0, 16'h0000,  1'b0, XY_ZERO},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h0001,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h5555,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hAAAA,  1'b1, XY_NONE},
    // step of 2^24, wrapping through minus pi
    '{ROW_CFG,  REG_ANGLE_STEP,  32'h0100_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_START_ANGLE, 32'h4000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h1234,  1'b1, XY_NONE},
    // exclusive band and rear edges
    '{ROW_CFG,  REG_BAND_LOW,    32'h4000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_BAND_HIGH,   32'h4200_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_REAR_LIMIT,  32'h4400_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_START_ANGLE, 32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'h1234,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h8000,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h7FFF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'd40000, 1'b0, XY_NONE},
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'h4321,  1'b0, XY_NONE},
    '{ROW_EXP,  REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b1, XY_END},
    // countdown left above a lowered decimation, zero decimation, spare indexes
    '{ROW_CFG,  REG_DECIMATION,  32'h0000_0004, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_ANGLE_STEP,  32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_BAND_LOW,    32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_BAND_HIGH,   32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  REG_REAR_LIMIT,  32'h8000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFFFF,  1'b0, XY_NONE},
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'd100,   1'b0, XY_NONE},
    '{ROW_CFG,  REG_DECIMATION,  32'h0000_0000, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  IDX_SPARE_A,     32'hFFFF_FFFF, 16'd0, 1'b0, XY_NONE},
    '{ROW_CFG,  IDX_SPARE_B,     32'hFFFF_FFFF, 16'd0, 1'b0, XY_NONE},
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'd200,   1'b0, XY_NONE},
    '{ROW_NONE, REG_START_ANGLE, 32'h0, 16'd300,   1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'h00FF,  1'b0, XY_NONE},
    '{ROW_PRED, REG_START_ANGLE, 32'h0, 16'hFF00,  1'b1, XY_NONE}
  };

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [31:0]          cfg_data     = '0;
  logic                 sample_valid = 1'b0;
  logic                 sample_ready;
  logic [15:0]          range_mm     = '0;
  logic                 scan_last    = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic signed [16:0]   pos_x;
  logic signed [16:0]   pos_y;
  logic                 point_valid;
  logic                 scan_end;

  scan_polar_to_cartesian_masked u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .range_mm     (range_mm),
    .scan_last    (scan_last),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .point_valid  (point_valid),
    .scan_end     (scan_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scan converter model state and setup copy
  logic [31:0] cf_start   = START_ANGLE_RESET;
  logic [24:0] cf_step    = ANGLE_STEP_RESET;
  logic [7:0]  cf_decim   = DECIMATION_RESET;
  logic [31:0] cf_band_lo = BAND_LOW_RESET;
  logic [31:0] cf_band_hi = BAND_HIGH_RESET;
  logic [31:0] cf_rear    = REAR_LIMIT_RESET;
  logic [31:0] scan_angle = START_ANGLE_RESET;
  logic [7:0]  skip_left  = '0;

  xy_result_t xy_expected [$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;

  int burst_left = 0;
  bit steady     = 1'b0;
  int scan_left  = 0;

  int hold_req_cnt = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int pat_left     = 0;
  int ready_pct    = 100;

  function automatic logic signed [16:0] scale_mm(input logic [15:0] rng, input longint c);
    longint r;
    longint v;
    r = rng;
    v = (r * c + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < -COORD_MAX) v = -COORD_MAX;
    return v[16:0];
  endfunction

  function automatic void cart_of_angle(input logic [31:0] ang, input logic [15:0] rng,
                                        output logic signed [16:0] px,
                                        output logic signed [16:0] py);
    logic [31:0] quarter_sum;
    logic [31:0] rot;
    logic        flip;
    longint      x;
    longint      y;
    longint      z;
    longint      dx;
    longint      dy;
    quarter_sum = ang + QUARTER_TURN;
    flip = quarter_sum[31];
    // rotate the back half by pi and negate at the end
    rot = flip ? ang + 32'h8000_0000 : ang;
    z = $signed(rot);
    x = X_INIT;
    y = 0;
    for (int i = 0; i < TRIG_BITS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_BAM[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_BAM[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    px = scale_mm(rng, x);
    py = scale_mm(rng, y);
  endfunction

  function automatic bit angle_masked(input logic [31:0] a);
    logic [31:0] mag;
    mag = a[31] ? 32'd0 - a : a;
    return (mag > cf_band_lo && mag < cf_band_hi) || (mag > cf_rear);
  endfunction

  function automatic void scan_step(input logic [15:0] rng, input logic last,
                                    output bit emits, output xy_result_t res);
    logic [31:0]        cur;
    bit                 used;
    logic signed [16:0] px;
    logic signed [16:0] py;
    cur = scan_angle;
    used = (skip_left == 8'd0);
    if (used) skip_left = ((cf_decim == 8'd0) ? 8'd1 : cf_decim) - 8'd1;
    else skip_left = skip_left - 8'd1;
    scan_angle = cur + 32'(cf_step);
    res = '0;
    if (used && !angle_masked(cur)) begin
      cart_of_angle(cur, rng, px, py);
      res.x = px;
      res.y = py;
      res.point = 1'b1;
    end
    if (last) begin
      scan_angle = cf_start;
      skip_left = '0;
    end
    res.last = last;
    emits = res.point || last;
  endfunction

  function automatic void take_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_START_ANGLE: cf_start   = data;
      REG_ANGLE_STEP:  cf_step    = data[24:0];
      REG_DECIMATION:  cf_decim   = data[7:0];
      REG_BAND_LOW:    cf_band_lo = data;
      REG_BAND_HIGH:   cf_band_hi = data;
      REG_REAR_LIMIT:  cf_rear    = data;
      default: ;
    endcase
  endfunction

  task automatic queue_prediction(input logic [15:0] rng, input logic last);
    bit         emits;
    xy_result_t res;
    scan_step(rng, last, emits, res);
    if (emits) xy_expected.insert(xy_expected.size(), res);
  endtask

  task automatic report_mismatch(input string msg);
    $display("[cycle %0d] mismatch: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic offer_sample(input logic [15:0] rng, input logic last);
    if (burst_left == 0) begin
      if (!steady)
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 3))
          @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    sample_valid <= 1'b1;
    range_mm     <= rng;
    scan_last    <= last;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    burst_left--;
    // drop valid at the end of a burst; a steady stream keeps it high
    if (burst_left == 0 && !steady) sample_valid <= 1'b0;
  endtask

  // drop valid right at the accepting edge, whatever the burst state
  task automatic end_burst();
    sample_valid <= 1'b0;
    burst_left = 0;
  endtask

  // drain results, then give beats that cause no result time to leave the pipe
  task automatic settle_pipeline();
    int beats;
    end_burst();
    while (xy_expected.size() != 0) @(posedge clk);
    beats = 0;
    while (beats < SETTLE_BEATS) begin
      @(posedge clk);
      if (result_ready) beats++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    take_reg(idx, data);
  endtask

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  task automatic setup_random(input int ph);
    logic [31:0] sa;
    logic [31:0] st;
    logic [31:0] dc;
    logic [31:0] bl;
    logic [31:0] bh;
    logic [31:0] rr;
    if (ph == 0) begin
      sa = 32'h8000_0000; st = 32'd0; dc = 32'd0;
      bl = 32'd0; bh = 32'd0; rr = 32'd0;
    end else if (ph == 1) begin
      sa = 32'h7FFF_FFFF; st = 32'h0100_0000; dc = 32'd255;
      bl = 32'h8000_0000; bh = 32'h8000_0000; rr = 32'h8000_0000;
    end else begin
      sa = pick_angle();
      case ($urandom_range(0, 4))
        0:       st = 32'd0;
        1:       st = 32'h0100_0000;
        2:       st = $urandom;
        default: st = $urandom_range(32'h0001_0000, 32'h0100_0000);
      endcase
      case ($urandom_range(0, 5))
        0:       dc = 32'd0;
        1:       dc = 32'd255;
        2:       dc = $urandom;
        default: dc = $urandom_range(1, 4);
      endcase
      bl = pick_limit();
      bh = pick_limit();
      rr = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : pick_limit();
    end
    if ($urandom_range(0, 2) == 0)
      write_reg(($urandom_range(0, 1) == 0) ? IDX_SPARE_A : IDX_SPARE_B, $urandom);
    write_reg(REG_START_ANGLE, sa);
    write_reg(REG_ANGLE_STEP, st);
    write_reg(REG_DECIMATION, dc);
    write_reg(REG_BAND_LOW, bl);
    write_reg(REG_BAND_HIGH, bh);
    write_reg(REG_REAR_LIMIT, rr);
  endtask

  task automatic random_samples(input int count);
    logic [15:0] rng;
    logic        last;
    for (int n = 0; n < count; n++) begin
      if (scan_left == 0)
        scan_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
      last = (scan_left == 1);
      scan_left--;
      // break the scan framing now and then
      if ($urandom_range(0, 15) == 0) last = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) rng = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
      else rng = 16'($urandom);
      offer_sample(rng, last);
      queue_prediction(rng, last);
    end
  endtask

  initial begin
    script_row_t row;
    bit          in_cfg;
    bit          emits;
    xy_result_t  res;
    in_cfg = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < SCRIPT_LEN; k++) begin
      row = SCRIPT[k];
      if (row.kind == ROW_CFG) begin
        if (!in_cfg) settle_pipeline();
        in_cfg = 1'b1;
        write_reg(row.idx, row.data);
      end else begin
        in_cfg = 1'b0;
        offer_sample(row.rng, row.last);
        if (row.kind == ROW_PRED) begin
          queue_prediction(row.rng, row.last);
        end else begin
          scan_step(row.rng, row.last, emits, res);
          if (row.kind == ROW_EXP) xy_expected.insert(xy_expected.size(), row.want);
        end
      end
    end

    // hold the receiver off while a steady stream fills the pipe
    settle_pipeline();
    write_reg(REG_START_ANGLE, 32'h0000_0000);
    write_reg(REG_ANGLE_STEP, $urandom_range(1, 32'h0100_0000));
    write_reg(REG_DECIMATION, 32'd1);
    write_reg(REG_BAND_LOW, 32'd0);
    write_reg(REG_BAND_HIGH, 32'd0);
    write_reg(REG_REAR_LIMIT, 32'h8000_0000);
    hold_req_cnt++;
    steady = 1'b1;
    random_samples(PRESS_ITEMS);
    steady = 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle_pipeline();
      setup_random(ph);
      random_samples(PHASE_ITEMS);
    end

    settle_pipeline();
    if (mismatch_count == 0) $display("tb_scan_polar_to_cartesian_masked passed");
    else $display("tb_scan_polar_to_cartesian_masked failed");
    $finish;
  end

  // receiver: random ready stretches, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_left = $urandom_range(4, 64);
        case ($urandom_range(0, 3))
          0:       ready_pct = 100;
          1:       ready_pct = 80;
          2:       ready_pct = 45;
          default: ready_pct = 15;
        endcase
      end
      pat_left = pat_left - 1;
      result_ready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk) begin
    xy_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (xy_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d point=%0b end=%0b",
                                  pos_x, pos_y, point_valid, scan_end));
      end else begin
        want = xy_expected.pop_front();
        if (pos_x !== want.x)
          report_mismatch($sformatf("pos_x got %0d want %0d", pos_x, want.x));
        if (pos_y !== want.y)
          report_mismatch($sformatf("pos_y got %0d want %0d", pos_y, want.y));
        if (point_valid !== want.point)
          report_mismatch($sformatf("point_valid got %0b want %0b", point_valid, want.point));
        if (scan_end !== want.last)
          report_mismatch($sformatf("scan_end got %0b want %0b", scan_end, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_scan_polar_to_cartesian_masked failed");
      $finish;
    end
  end

endmodule
